// File: src/tpq_pkg.sv
package tpq_pkg;

    localparam int DEPTH       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DL_W        = 63;
    localparam int HDL_W       = 16;
    localparam int OCC_W       = 6;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // stream payload widths, rounded up to whole bytes
    localparam int S_FIELDS_W = DL_W + HDL_W + DL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = HDL_W + DL_W + 1 + DL_W + OCC_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRED = 2'd0,
        KIND_NONE    = 2'd1,
        KIND_ADDED   = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef enum logic {
        ACT_ADD = 1'b0,
        ACT_POP = 1'b1
    } action_t;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [HDL_W-1:0] handle;
    } entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic ins;      // insert the new entry in order
        logic pop;      // shift everything one cell toward the head
        logic valid;    // this cell holds a live entry
        logic prev_gt;  // neighbor toward the head is later than the new entry
    } cell_ctrl_t;

endpackage

// File: src/tpq_cell.sv
module tpq_cell (
    input  logic               aclk,
    input  tpq_pkg::cell_ctrl_t ctrl,
    input  tpq_pkg::entry_t    new_entry,
    input  tpq_pkg::entry_t    left_entry,
    input  tpq_pkg::entry_t    right_entry,
    output tpq_pkg::entry_t    entry,
    output logic               gt
);
    import tpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // strictly later: equal deadlines keep insertion order
    assign gt = ctrl.valid && (entry_reg.deadline > new_entry.deadline);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.pop) begin
            entry_next = right_entry;
        end else if (ctrl.ins) begin
            if (ctrl.prev_gt) begin
                entry_next = left_entry;
            end else if (gt || !ctrl.valid) begin
                // first later cell, or the tail; cells past the tail are don't-care
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: src/timeout_priority_queue.sv
// Sorted timer queue built as a row of cells, head cell holds the earliest timeout.
// Add: parallel insert in ST_ADD, then the result is reported from ST_REPORT.
// Pop: one expired entry per cycle while the result side keeps up, the cell row
// shifting one cell toward the head for each expired entry.
// One request in flight; the next is taken once its last result is registered.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module timeout_priority_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [62:0] deadline, [78:63] handle_in, [141:79] current_time, rest zero
    input  logic [tpq_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] handle_out, [78:16] expired_deadline, [79] queue_empty,
    // [142:80] earliest_deadline, [148:143] occupancy, rest zero
    output logic [tpq_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] kind
    output logic [tpq_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import tpq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_REPORT,
        ST_POP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RES_W-1:0] n_reg, n_next;
    entry_t           req_reg, req_next;
    logic [DL_W-1:0]  now_reg, now_next;
    kind_t            pend_reg, pend_next;

    logic             m_valid_reg, m_valid_next;
    kind_t            m_kind_reg, m_kind_next;
    logic [HDL_W-1:0] m_handle_reg, m_handle_next;
    logic [DL_W-1:0]  m_exp_reg, m_exp_next;
    logic             m_last_reg, m_last_next;
    logic             m_empty_reg, m_empty_next;
    logic [DL_W-1:0]  m_early_reg, m_early_next;
    logic [OCC_W-1:0] m_occ_reg, m_occ_next;

    entry_t     cell_q [DEPTH];
    logic       gt_w   [DEPTH];
    cell_ctrl_t ctrl_w [DEPTH];

    logic s_fire;
    logic out_free;
    logic do_ins;
    logic pop_shift;
    logic head_exp;
    logic next_exp;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign head_exp = (count_reg != '0) && (cell_q[0].deadline <= now_reg);
    assign next_exp = (count_reg > CNT_W'(1)) && (cell_q[1].deadline <= now_reg)
                      && (n_reg < RES_W'(MAX_RESULTS - 1));

    assign do_ins    = (state_reg == ST_ADD) && (count_reg < CNT_W'(DEPTH));
    assign pop_shift = (state_reg == ST_POP) && out_free && head_exp;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t left_w;
        entry_t right_w;
        logic   prev_w;

        if (i == 0) begin : g_head
            assign left_w = req_reg;
            assign prev_w = 1'b0;
        end else begin : g_body
            assign left_w = cell_q[i-1];
            assign prev_w = gt_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_w = cell_q[i];
        end else begin : g_mid
            assign right_w = cell_q[i+1];
        end

        assign ctrl_w[i] = '{ins:     do_ins,
                             pop:     pop_shift,
                             valid:   (CNT_W'(i) < count_reg),
                             prev_gt: prev_w};

        tpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl_w[i]),
            .new_entry   (req_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (cell_q[i]),
            .gt          (gt_w[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        req_next      = req_reg;
        now_next      = now_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_handle_next = m_handle_reg;
        m_exp_next    = m_exp_reg;
        m_last_next   = m_last_reg;
        m_empty_next  = m_empty_reg;
        m_early_next  = m_early_reg;
        m_occ_next    = m_occ_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next.deadline = s_tdata[DL_W-1:0];
                    req_next.handle   = s_tdata[DL_W +: HDL_W];
                    now_next          = s_tdata[DL_W + HDL_W +: DL_W];
                    n_next            = '0;
                    state_next        = (action_t'(s_tuser) == ACT_POP) ? ST_POP : ST_ADD;
                end
            end
            ST_ADD: begin
                if (do_ins) begin
                    count_next = count_reg + CNT_W'(1);
                    pend_next  = KIND_ADDED;
                end else begin
                    pend_next  = KIND_FULL;
                end
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = pend_reg;
                    m_handle_next = '0;
                    m_exp_next    = '0;
                    m_last_next   = 1'b1;
                    m_empty_next  = (count_reg == '0);
                    m_early_next  = (count_reg != '0) ? cell_q[0].deadline : '0;
                    m_occ_next    = OCC_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (head_exp) begin
                        // report the head, state seen after it leaves
                        m_kind_next   = KIND_EXPIRED;
                        m_handle_next = cell_q[0].handle;
                        m_exp_next    = cell_q[0].deadline;
                        m_last_next   = !next_exp;
                        m_empty_next  = (count_reg == CNT_W'(1));
                        m_early_next  = (count_reg > CNT_W'(1)) ? cell_q[1].deadline : '0;
                        m_occ_next    = OCC_W'(count_reg - CNT_W'(1));
                        count_next    = count_reg - CNT_W'(1);
                        n_next        = n_reg + RES_W'(1);
                        if (!next_exp) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_kind_next   = KIND_NONE;
                        m_handle_next = '0;
                        m_exp_next    = '0;
                        m_last_next   = 1'b1;
                        m_empty_next  = (count_reg == '0);
                        m_early_next  = (count_reg != '0) ? cell_q[0].deadline : '0;
                        m_occ_next    = OCC_W'(count_reg);
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg      <= req_next;
        now_reg      <= now_next;
        pend_reg     <= pend_next;
        m_kind_reg   <= m_kind_next;
        m_handle_reg <= m_handle_next;
        m_exp_reg    <= m_exp_next;
        m_last_reg   <= m_last_next;
        m_empty_reg  <= m_empty_next;
        m_early_reg  <= m_early_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, m_occ_reg, m_early_reg,
                       m_empty_reg, m_exp_reg, m_handle_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > CNT_W'(1)) |-> (cell_q[0].deadline <= cell_q[1].deadline))
        else $error("head cells out of order");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_shift |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("expiry did not drop the count");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT && pend_reg == KIND_FULL) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("add rejected while queue not full");

endmodule
